FILE: sv/sorr_pkg.sv
package sorr_pkg;

    localparam logic [31:0] EPOCH_DELTA   = 32'd2208988800;
    localparam logic [20:0] USEC_PER_SEC  = 21'd1000000;
    localparam logic [20:0] HALF_SEC_USEC = 21'd500000;
    localparam logic [19:0] USEC_MAX      = 20'd999999;
    localparam logic [13:0] FRAC_USEC_MUL = 14'd15625;
    localparam logic [2:0]  MODE_SERVER   = 3'd4;

    typedef struct packed {
        logic signed [31:0] t1_sec;
        logic [19:0]        t1_usec;
        logic signed [31:0] t4_sec;
        logic [19:0]        t4_usec;
        logic [31:0]        t2_ntp_sec;
        logic [31:0]        t2_ntp_frac;
        logic [31:0]        t3_ntp_sec;
        logic [31:0]        t3_ntp_frac;
        logic [31:0]        origin_ntp_sec;
        logic [7:0]         header_byte;
        logic [7:0]         stratum;
    } exch_t;

    typedef struct packed {
        logic signed [31:0] offset_sec;
        logic [19:0]        offset_usec;
        logic signed [31:0] round_trip_sec;
        logic [19:0]        round_trip_usec;
        logic               accepted;
    } res_t;

endpackage

FILE: sv/sntp_offset_and_round_trip.sv
// channel   dir  handshake               payload
// exch      in   exch_valid/exch_stall   exch_t, one sntp exchange
// res       out  res_valid/res_stall     res_t, offset, round trip, accept flag
//
// one beat per cycle while the result side is not stalled; an exch beat passes
// through the input register, then the time arithmetic and fraction multipliers
// into the result register, before res_valid rises.
// rst_n clears the two valid flags only; payload registers are not reset.
// a stalled result holds; the input register still takes a beat while it is empty.
module sntp_offset_and_round_trip
    import sorr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  exch_valid,
    output logic  exch_stall,
    input  exch_t exch,
    output logic  res_valid,
    input  logic  res_stall,
    output res_t  res
);

    typedef struct packed {
        logic [31:0] sec;
        logic [19:0] usec;
    } tstamp_t;

    function automatic tstamp_t ts_sub(tstamp_t a, tstamp_t b);
        tstamp_t     d;
        logic [20:0] diff;
        d.sec = a.sec - b.sec;
        if (a.usec < b.usec)
        begin
            diff  = {1'b0, a.usec} + USEC_PER_SEC - {1'b0, b.usec};
            d.sec = d.sec - 32'd1;
        end
        else
        begin
            diff = {1'b0, a.usec} - {1'b0, b.usec};
        end
        d.usec = diff[19:0];
        return d;
    endfunction

    function automatic tstamp_t ts_add(tstamp_t a, tstamp_t b);
        tstamp_t     d;
        logic [20:0] sum;
        d.sec = a.sec + b.sec;
        sum   = {1'b0, a.usec} + {1'b0, b.usec};
        if (sum >= USEC_PER_SEC)
        begin
            sum   = sum - USEC_PER_SEC;
            d.sec = d.sec + 32'd1;
        end
        d.usec = sum[19:0];
        return d;
    endfunction

    // arithmetic shift of the seconds, odd second carried into the microseconds
    function automatic tstamp_t ts_half(tstamp_t a);
        tstamp_t     d;
        logic [20:0] hu;
        d.sec = {a.sec[31], a.sec[31:1]};
        hu    = {2'b00, a.usec[19:1]} + (a.sec[0] ? HALF_SEC_USEC : 21'd0);
        if (hu >= USEC_PER_SEC)
        begin
            hu    = hu - USEC_PER_SEC;
            d.sec = d.sec + 32'd1;
        end
        d.usec = hu[19:0];
        return d;
    endfunction

    function automatic logic [19:0] sat_usec(logic [19:0] u);
        return ({1'b0, u} >= USEC_PER_SEC) ? USEC_MAX : u;
    endfunction

    exch_t   exch_reg;
    logic    exch_valid_reg;
    res_t    res_reg;
    res_t    res_next;
    logic    res_valid_reg;
    logic    res_adv;
    logic    exch_adv;

    tstamp_t t1;
    tstamp_t t2;
    tstamp_t t3;
    tstamp_t t4;
    tstamp_t off;
    tstamp_t rtt;
    logic [29:0] t2_prod;
    logic [29:0] t3_prod;
    logic [31:0] origin;

    assign res_adv    = !res_valid_reg || !res_stall;
    assign exch_adv   = !exch_valid_reg || res_adv;
    assign exch_stall = !exch_adv;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        t1.sec   = exch_reg.t1_sec;
        t1.usec  = sat_usec(exch_reg.t1_usec);
        t4.sec   = exch_reg.t4_sec;
        t4.usec  = sat_usec(exch_reg.t4_usec);

        // frac to usec: top 16 bits * 15625 / 1024
        t2_prod  = {14'd0, exch_reg.t2_ntp_frac[31:16]} * {16'd0, FRAC_USEC_MUL};
        t3_prod  = {14'd0, exch_reg.t3_ntp_frac[31:16]} * {16'd0, FRAC_USEC_MUL};
        t2.sec   = exch_reg.t2_ntp_sec - EPOCH_DELTA;
        t2.usec  = t2_prod[29:10];
        t3.sec   = exch_reg.t3_ntp_sec - EPOCH_DELTA;
        t3.usec  = t3_prod[29:10];
        origin   = exch_reg.origin_ntp_sec - EPOCH_DELTA;

        off = ts_half(ts_add(ts_sub(t2, t1), ts_sub(t3, t4)));
        rtt = ts_sub(ts_sub(t4, t1), ts_sub(t3, t2));

        res_next.offset_sec      = off.sec;
        res_next.offset_usec     = off.usec;
        res_next.round_trip_sec  = rtt.sec;
        res_next.round_trip_usec = rtt.usec;
        res_next.accepted        = (exch_reg.header_byte[2:0] == MODE_SERVER)
                                   && (exch_reg.stratum != 8'd0)
                                   && (origin == t1.sec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exch_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (exch_adv)
            begin
                exch_valid_reg <= exch_valid;
            end
            if (res_adv)
            begin
                res_valid_reg <= exch_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exch_adv && exch_valid)
        begin
            exch_reg <= exch;
        end
        if (res_adv && exch_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: sv/sorr_checker.sv
module sorr_checker
    import sorr_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  exch_valid,
    input logic  exch_stall,
    input logic  res_valid,
    input logic  res_stall,
    input res_t  res
);

    // a held result stays up
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result beat changed");

    // an accepted beat passes the input register and reaches the result register
    // when the result side is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (exch_valid && !exch_stall) ##1 !res_stall |=> res_valid)
        else $error("accepted beat did not reach the result");

    // input side never stalls while the result side is empty
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !exch_stall)
        else $error("input stalled with empty result register");

    a_usec_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.offset_usec < 20'd1000000)
                      && (res.round_trip_usec < 20'd1000000))
        else $error("microseconds out of range");

endmodule

bind sntp_offset_and_round_trip sorr_checker u_sorr_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sorr_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RAND_PER_SET = 510;

    typedef struct packed {
        logic [31:0] sec;
        logic [31:0] usec;
    } tv_t;

    typedef struct {
        exch_t beat;
        bit    typed;
        res_t  exp;
    } dir_row_t;

    logic  clk;
    logic  rst_n      = 1'b0;
    logic  exch_valid = 1'b0;
    logic  exch_stall;
    exch_t exch       = '0;
    logic  res_valid;
    logic  res_stall  = 1'b0;
    res_t  res;

    res_t        offset_rtt_q[$];
    dir_row_t    dir_rows[$];
    int          send_idle_pct  = 32;
    int          recv_stall_pct = 81;
    int          mismatches     = 0;
    int unsigned cycle_cnt      = 0;

    sntp_offset_and_round_trip dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .exch_valid (exch_valid),
        .exch_stall (exch_stall),
        .exch       (exch),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [31:0] clamp_usec(input logic [19:0] u);
        return (u >= USEC_PER_SEC) ? 32'(USEC_MAX) : 32'(u);
    endfunction

    function automatic tv_t ntp_to_unix(input logic [31:0] nsec, input logic [31:0] frac);
        tv_t t;
        t.sec  = nsec - EPOCH_DELTA;
        t.usec = (32'(frac[31:16]) * 32'd15625) >> 10;
        return t;
    endfunction

    function automatic tv_t tv_sub(input tv_t a, input tv_t b);
        tv_t d;
        d.sec = a.sec - b.sec;
        if (a.usec < b.usec)
        begin
            d.usec = a.usec + USEC_PER_SEC - b.usec;
            d.sec  = d.sec - 32'd1;
        end
        else
        begin
            d.usec = a.usec - b.usec;
        end
        return d;
    endfunction

    function automatic tv_t tv_add(input tv_t a, input tv_t b);
        tv_t d;
        d.sec  = a.sec + b.sec;
        d.usec = a.usec + b.usec;
        if (d.usec >= USEC_PER_SEC)
        begin
            d.usec = d.usec - USEC_PER_SEC;
            d.sec  = d.sec + 32'd1;
        end
        return d;
    endfunction

    function automatic res_t calc_offset_rtt(input exch_t b);
        tv_t         t1, t2, t3, t4, sum, off, rtt;
        logic [31:0] origin;
        res_t        r;
        t1.sec  = b.t1_sec;
        t1.usec = clamp_usec(b.t1_usec);
        t4.sec  = b.t4_sec;
        t4.usec = clamp_usec(b.t4_usec);
        t2 = ntp_to_unix(b.t2_ntp_sec, b.t2_ntp_frac);
        t3 = ntp_to_unix(b.t3_ntp_sec, b.t3_ntp_frac);
        sum = tv_add(tv_sub(t2, t1), tv_sub(t3, t4));
        // arithmetic shift floors; odd seconds carry half a second down
        // (usec/2 + 500000 stays below one second, so no renormalise)
        off.sec  = {sum.sec[31], sum.sec[31:1]};
        off.usec = sum.usec / 2 + (sum.sec[0] ? 32'(HALF_SEC_USEC) : 32'd0);
        rtt = tv_sub(tv_sub(t4, t1), tv_sub(t3, t2));
        origin = b.origin_ntp_sec - EPOCH_DELTA;
        r.offset_sec      = off.sec;
        r.offset_usec     = 20'(off.usec);
        r.round_trip_sec  = rtt.sec;
        r.round_trip_usec = 20'(rtt.usec);
        r.accepted        = (b.header_byte[2:0] == MODE_SERVER) && (b.stratum != 8'd0)
                            && (origin == t1.sec);
        return r;
    endfunction

    function automatic exch_t exch_of(input logic [31:0] t1s, input logic [31:0] t1u,
                                      input logic [31:0] t4s, input logic [31:0] t4u,
                                      input logic [31:0] t2s, input logic [31:0] t2f,
                                      input logic [31:0] t3s, input logic [31:0] t3f,
                                      input logic [31:0] org, input logic [7:0] hdr,
                                      input logic [7:0] strat);
        exch_t b;
        b.t1_sec         = t1s;
        b.t1_usec        = 20'(t1u);
        b.t4_sec         = t4s;
        b.t4_usec        = 20'(t4u);
        b.t2_ntp_sec     = t2s;
        b.t2_ntp_frac    = t2f;
        b.t3_ntp_sec     = t3s;
        b.t3_ntp_frac    = t3f;
        b.origin_ntp_sec = org;
        b.header_byte    = hdr;
        b.stratum        = strat;
        return b;
    endfunction

    function automatic res_t res_of(input logic [31:0] os, input logic [31:0] ou,
                                    input logic [31:0] rs, input logic [31:0] ru,
                                    input logic acc);
        res_t r;
        r.offset_sec      = os;
        r.offset_usec     = 20'(ou);
        r.round_trip_sec  = rs;
        r.round_trip_usec = 20'(ru);
        r.accepted        = acc;
        return r;
    endfunction

    function automatic void add_row(input exch_t b, input bit typed, input res_t e);
        dir_row_t row;
        row.beat  = b;
        row.typed = typed;
        row.exp   = e;
        dir_rows.push_back(row);
    endfunction

    // mostly plausible exchanges around T1, the rest raw noise
    function automatic exch_t make_exchange();
        exch_t b;
        if ($urandom_range(0, 9) < 7)
        begin
            b.t1_sec         = $urandom;
            b.t1_usec        = 20'($urandom_range(0, 999999));
            b.t4_sec         = b.t1_sec + $urandom_range(0, 2);
            b.t4_usec        = 20'($urandom_range(0, 999999));
            b.t2_ntp_sec     = b.t1_sec + EPOCH_DELTA + $urandom_range(0, 200) - 32'd100;
            b.t2_ntp_frac    = $urandom;
            b.t3_ntp_sec     = b.t2_ntp_sec + $urandom_range(0, 1);
            b.t3_ntp_frac    = $urandom;
            b.origin_ntp_sec = b.t1_sec + EPOCH_DELTA
                               + 32'($urandom_range(0, 19) == 0);
            b.header_byte    = {5'($urandom), MODE_SERVER};
            if ($urandom_range(0, 19) == 0)
                b.header_byte[2:0] = 3'($urandom);
            b.stratum = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 15));
        end
        else
        begin
            b.t1_sec         = $urandom;
            b.t1_usec        = $urandom_range(0, 1) ? 20'($urandom)
                                                    : 20'($urandom_range(0, 999999));
            b.t4_sec         = $urandom;
            b.t4_usec        = $urandom_range(0, 1) ? 20'($urandom)
                                                    : 20'($urandom_range(0, 999999));
            b.t2_ntp_sec     = $urandom;
            b.t2_ntp_frac    = $urandom;
            b.t3_ntp_sec     = $urandom;
            b.t3_ntp_frac    = $urandom;
            b.origin_ntp_sec = $urandom;
            b.header_byte    = 8'($urandom);
            b.stratum        = 8'($urandom);
        end
        return b;
    endfunction

    task automatic send_exchange(input exch_t b, input bit typed, input res_t typed_res);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            exch_valid <= 1'b0;
            @(posedge clk);
        end
        exch_valid <= 1'b1;
        exch       <= b;
        @(posedge clk);
        while (exch_stall)
            @(posedge clk);
        offset_rtt_q.push_back(typed ? typed_res : calc_offset_rtt(b));
    endtask

    // called right at an accepting edge; holds off until every result is back
    task automatic drain_results();
        exch_valid <= 1'b0;
        do
            @(posedge clk);
        while (offset_rtt_q.size() != 0);
    endtask

    always @(posedge clk)
    begin
        res_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : res_check
        res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (offset_rtt_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: off %0d.%06d rtt %0d.%06d acc %0b",
                             $signed(res.offset_sec), res.offset_usec,
                             $signed(res.round_trip_sec), res.round_trip_usec, res.accepted);
            end
            else
            begin
                e = offset_rtt_q.pop_front();
                if (res.offset_sec !== e.offset_sec || res.offset_usec !== e.offset_usec
                    || res.round_trip_sec !== e.round_trip_sec
                    || res.round_trip_usec !== e.round_trip_usec
                    || res.accepted !== e.accepted)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp off %0d.%06d rtt %0d.%06d acc %0b / got off %0d.%06d rtt %0d.%06d acc %0b",
                                 $signed(e.offset_sec), e.offset_usec,
                                 $signed(e.round_trip_sec), e.round_trip_usec, e.accepted,
                                 $signed(res.offset_sec), res.offset_usec,
                                 $signed(res.round_trip_sec), res.round_trip_usec,
                                 res.accepted);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("** sntp_offset_and_round_trip: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] ep;
        ep = EPOCH_DELTA;

        // all times at unix zero; only the accept conditions move
        for (int m = 0; m < 8; m++)
            add_row(exch_of(0, 0, 0, 0, ep, 0, ep, 0, ep, {5'b10101, 3'(m)}, 8'd1),
                    1'b1, res_of(0, 0, 0, 0, 3'(m) == MODE_SERVER));
        add_row(exch_of(0, 0, 0, 0, ep, 0, ep, 0, ep, 8'h04, 8'd0), 1'b1, res_of(0, 0, 0, 0, 0));
        add_row(exch_of(0, 0, 0, 0, ep, 0, ep, 0, ep, 8'hFC, 8'hFF), 1'b1, res_of(0, 0, 0, 0, 1));
        add_row(exch_of(0, 0, 0, 0, ep, 0, ep, 0, ep + 32'd1, 8'h04, 8'd1), 1'b1,
                res_of(0, 0, 0, 0, 0));
        // out-of-range microseconds saturate
        add_row(exch_of(0, 20'hFFFFF, 0, 20'hFFFFF, ep, 0, ep, 0, ep, 8'h04, 8'd1), 1'b1,
                res_of(32'hFFFF_FFFF, 1, 0, 0, 1));
        // largest fraction
        add_row(exch_of(0, 0, 0, 0, ep, 32'hFFFF_FFFF, ep, 0, ep, 8'h04, 8'd1), 1'b1,
                res_of(0, 499992, 0, 999984, 1));
        // odd sum halved, positive and negative
        add_row(exch_of(0, 0, 0, 0, ep + 32'd1, 0, ep, 0, ep, 8'h04, 8'd1), 1'b1,
                res_of(0, 500000, 1, 0, 1));
        add_row(exch_of(0, 0, 1, 0, ep, 0, ep, 0, ep, 8'h04, 8'd1), 1'b1,
                res_of(32'hFFFF_FFFF, 500000, 1, 0, 1));
        // seconds wrap at the signed extremes
        add_row(exch_of(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, ep, 0, ep, 0, ep, 8'h00, 8'h00),
                1'b1, res_of(0, 500000, 32'hFFFF_FFFF, 0, 0));
        add_row(exch_of(5, 999999, 7, 1000000, ep + 32'd3, 32'h8000_0000, ep + 32'd4,
                        32'h0001_0000, ep + 32'd5, 8'h04, 8'd2), 1'b0, '0);
        add_row(exch_of(32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        8'hFF, 8'hFF), 1'b0, '0);
        add_row(exch_of(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 8'h07, 8'h01),
                1'b0, '0);
        add_row(exch_of(32'h7FFF_FFFF, 999999, 32'h8000_0000, 0, 32'h1234_5678, 32'h0000_FFFF,
                        32'hFEDC_BA98, 32'hFFFF_0000, 32'h7FFF_FFFF + ep, 8'h24, 8'd15),
                1'b0, '0);

        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_exchange(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].exp);
        drain_results();

        for (int set = 0; set < 3; set++)
        begin
            send_idle_pct  = (set == 0) ? 32 : (set == 1) ? 81 : 0;
            recv_stall_pct = (set == 0) ? 81 : (set == 1) ? 32 : 0;
            for (int i = 0; i < RAND_PER_SET; i++)
                send_exchange(make_exchange(), 1'b0, '0);
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && offset_rtt_q.size() == 0)
            $display("** sntp_offset_and_round_trip: PASSED **");
        else
            $display("** sntp_offset_and_round_trip: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
sv/sorr_pkg.sv
sv/sntp_offset_and_round_trip.sv
sv/sorr_checker.sv
tb/sv/tb_top.sv
